[rtl/pcsf_pkg.sv]
// ----------------------------------------------------------------------------
// pcsf_pkg
// Shared types, constants and helpers of the per-channel sample filter.
// ----------------------------------------------------------------------------
package pcsf_pkg;

   localparam int NUM_CODES    = 64;
   localparam int NUM_SOURCES  = 4;
   localparam int TIME_BITS    = 48;

   localparam int CODE_BITS    = 6;
   localparam int SRC_BITS     = 2;
   localparam int PERIOD_BITS  = 32;
   localparam int MASK_BITS    = 64;
   localparam int MASK_REGS    = 4;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;

   localparam int NUM_CHANNELS = NUM_SOURCES * NUM_CODES;
   localparam int CHAN_BITS    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [CHAN_BITS-1:0] chan_addr_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_MIN_PERIOD = 3'd0,
      REG_GAP_THRESH = 3'd1,
      REG_GPS_CODE   = 3'd2,
      REG_MASK_SRC0  = 3'd3,
      REG_MASK_SRC1  = 3'd4,
      REG_MASK_SRC2  = 3'd5,
      REG_MASK_SRC3  = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      REASON_KEPT        = 2'd0,
      REASON_ORDER       = 2'd1,
      REASON_REMOVED     = 2'd2,
      REASON_DOWNSAMPLED = 2'd3
   } reason_type;

   typedef struct packed {
      logic [PERIOD_BITS-1:0]                min_period;
      logic [PERIOD_BITS-1:0]                gap_thresh;
      logic [CODE_BITS-1:0]                  gps_code;
      logic [MASK_REGS-1:0][MASK_BITS-1:0]   remove_mask;
   } cfg_type;

   typedef struct packed {
      logic     valid;
      time_type last_time;
   } tab_look_type;

   typedef struct packed {
      logic          en;
      chan_addr_type addr;
      time_type      last_time;
   } tab_wr_type;

   typedef struct packed {
      logic       keep;
      reason_type drop_reason;
      logic       segment_start;
   } result_type;

   function automatic chan_addr_type chan_index(input logic [SRC_BITS-1:0]  src,
                                                input logic [CODE_BITS-1:0] code);
      int flat;
      flat = int'(src) * NUM_CODES + int'(code);
      return CHAN_BITS'(flat);
   endfunction

endpackage

[rtl/pcsf_intf.sv]
// ----------------------------------------------------------------------------
// pcsf request and response channels
// Valid/ready channels carrying one sample request and one filter response.
// ----------------------------------------------------------------------------
interface pcsf_req_if;
   logic                             valid;
   logic                             ready;
   logic [pcsf_pkg::TIME_BITS-1:0]   time_ms;
   logic [pcsf_pkg::CODE_BITS-1:0]   data_code;
   logic [pcsf_pkg::SRC_BITS-1:0]    source_id;

   modport source (output valid, output time_ms, output data_code, output source_id,
                   input ready);
   modport sink   (input valid, input time_ms, input data_code, input source_id,
                   output ready);
endinterface

interface pcsf_rsp_if;
   logic       valid;
   logic       ready;
   logic       keep;
   logic [1:0] drop_reason;
   logic       segment_start;

   modport source (output valid, output keep, output drop_reason, output segment_start,
                   input ready);
   modport sink   (input valid, input keep, input drop_reason, input segment_start,
                   output ready);
endinterface

[rtl/pcsf_csr.sv]
// ----------------------------------------------------------------------------
// pcsf_csr
// Configuration registers: interval, GPS gap, GPS code and removal masks.
// ----------------------------------------------------------------------------
module pcsf_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  write_en,
   input  logic [pcsf_pkg::CSR_IDX_BITS-1:0]     index,
   input  logic [pcsf_pkg::CSR_DATA_BITS-1:0]    write_data,
   output pcsf_pkg::cfg_type                     cfg
);

   pcsf_pkg::cfg_type cfg_ff;
   pcsf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            pcsf_pkg::REG_MIN_PERIOD:
               cfg_in.min_period = write_data[pcsf_pkg::PERIOD_BITS-1:0];
            pcsf_pkg::REG_GAP_THRESH:
               cfg_in.gap_thresh = write_data[pcsf_pkg::PERIOD_BITS-1:0];
            pcsf_pkg::REG_GPS_CODE:
               cfg_in.gps_code = write_data[pcsf_pkg::CODE_BITS-1:0];
            pcsf_pkg::REG_MASK_SRC0:
               cfg_in.remove_mask[0] = write_data[pcsf_pkg::MASK_BITS-1:0];
            pcsf_pkg::REG_MASK_SRC1:
               cfg_in.remove_mask[1] = write_data[pcsf_pkg::MASK_BITS-1:0];
            pcsf_pkg::REG_MASK_SRC2:
               cfg_in.remove_mask[2] = write_data[pcsf_pkg::MASK_BITS-1:0];
            pcsf_pkg::REG_MASK_SRC3:
               cfg_in.remove_mask[3] = write_data[pcsf_pkg::MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/pcsf_chan_tab.sv]
// ----------------------------------------------------------------------------
// pcsf_chan_tab
// Per-channel last-time memory with valid bits and a write bypass register.
// ----------------------------------------------------------------------------
module pcsf_chan_tab (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  pcsf_pkg::chan_addr_type    rd_addr,
   input  pcsf_pkg::tab_wr_type       wr,
   output pcsf_pkg::tab_look_type     look
);

   pcsf_pkg::time_type                   mem [pcsf_pkg::NUM_CHANNELS];
   logic [pcsf_pkg::NUM_CHANNELS-1:0]    valid_ff;
   pcsf_pkg::time_type                   rd_data_ff;
   pcsf_pkg::chan_addr_type              rd_addr_ff;
   logic                                 byp_valid_ff;
   pcsf_pkg::chan_addr_type              byp_addr_ff;
   pcsf_pkg::time_type                   byp_time_ff;
   logic                                 byp_hit;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.last_time;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (wr.en) begin
         byp_addr_ff <= wr.addr;
         byp_time_ff <= wr.last_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         byp_valid_ff <= 1'b0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
         byp_valid_ff      <= 1'b1;
      end
   end

   // take the latest write when it landed on the entry just read
   assign byp_hit        = byp_valid_ff && (byp_addr_ff == rd_addr_ff);
   assign look.valid     = valid_ff[rd_addr_ff];
   assign look.last_time = byp_hit ? byp_time_ff : rd_data_ff;

endmodule

[rtl/pcsf_decide.sv]
// ----------------------------------------------------------------------------
// pcsf_decide
// Applies the order, removal, interval and GPS segment rules to one sample.
// ----------------------------------------------------------------------------
module pcsf_decide (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              commit,
   input  pcsf_pkg::time_type                time_ms,
   input  logic [pcsf_pkg::CODE_BITS-1:0]    data_code,
   input  logic [pcsf_pkg::SRC_BITS-1:0]     source_id,
   input  pcsf_pkg::cfg_type                 cfg,
   input  pcsf_pkg::tab_look_type            look,
   output pcsf_pkg::result_type              result,
   output pcsf_pkg::tab_wr_type              tab_wr
);

   pcsf_pkg::time_type last_time_ff;
   logic               last_valid_ff;
   pcsf_pkg::time_type gps_time_ff;
   logic               gps_valid_ff;

   logic               out_of_order;
   logic               unknown;
   logic               removed;
   logic               chan_ge;
   pcsf_pkg::time_type chan_diff;
   logic               too_soon;
   logic               keep;
   logic               is_gps;
   logic               gps_ge;
   pcsf_pkg::time_type gps_diff;
   logic               seg;

   always_comb begin
      out_of_order = last_valid_ff && (time_ms < last_time_ff);
      unknown      = (int'(source_id) >= pcsf_pkg::NUM_SOURCES) ||
                     (int'(data_code) >= pcsf_pkg::NUM_CODES);
      removed      = unknown || cfg.remove_mask[source_id][data_code];
      chan_ge      = time_ms >= look.last_time;
      chan_diff    = time_ms - look.last_time;
      too_soon     = look.valid &&
                     (!chan_ge ||
                      (chan_diff < pcsf_pkg::TIME_BITS'(cfg.min_period)));
      keep         = !out_of_order && !removed && !too_soon;
      is_gps       = data_code == cfg.gps_code;
      gps_ge       = time_ms >= gps_time_ff;
      gps_diff     = time_ms - gps_time_ff;
      seg          = keep && is_gps &&
                     (!gps_valid_ff ||
                      (gps_ge && (gps_diff > pcsf_pkg::TIME_BITS'(cfg.gap_thresh))));

      result.keep          = keep;
      result.segment_start = seg;
      if (out_of_order) begin
         result.drop_reason = pcsf_pkg::REASON_ORDER;
      end else if (removed) begin
         result.drop_reason = pcsf_pkg::REASON_REMOVED;
      end else if (too_soon) begin
         result.drop_reason = pcsf_pkg::REASON_DOWNSAMPLED;
      end else begin
         result.drop_reason = pcsf_pkg::REASON_KEPT;
      end

      tab_wr.en        = commit && keep;
      tab_wr.addr      = pcsf_pkg::chan_index(source_id, data_code);
      tab_wr.last_time = time_ms;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff  <= '0;
         last_valid_ff <= 1'b0;
         gps_time_ff   <= '0;
         gps_valid_ff  <= 1'b0;
      end else if (commit) begin
         if (!out_of_order) begin
            last_time_ff  <= time_ms;
            last_valid_ff <= 1'b1;
         end
         if (keep && is_gps) begin
            gps_time_ff  <= time_ms;
            gps_valid_ff <= 1'b1;
         end
      end
   end

endmodule

[rtl/per_channel_sample_filter.sv]
// ----------------------------------------------------------------------------
// per_channel_sample_filter
// Each request is one timed sample; each gives exactly one response, in order,
// from the output register. One request is taken every cycle unless responses
// stall: the channel table is a single memory read at acceptance and written
// by the decision stage on commit, with a bypass register closing that
// read-after-write gap, and an output register lets a new request enter while
// a response waits. Channel valid bits clear at reset, so no clearing pass is
// needed. Configuration is written through the csr_ port while idle.
// ----------------------------------------------------------------------------
module per_channel_sample_filter (
   input  logic                                  clock,
   input  logic                                  reset,
   pcsf_req_if.sink                              req_bus,
   pcsf_rsp_if.source                            rsp_bus,
   input  logic                                  csr_write_en,
   input  logic [pcsf_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [pcsf_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   pcsf_pkg::cfg_type                  cfg;
   pcsf_pkg::tab_look_type             look;
   pcsf_pkg::tab_wr_type               tab_wr;
   pcsf_pkg::result_type               result;

   logic                               req_accept;
   logic                               s1_commit;

   logic                               s1_valid_ff;
   logic                               s1_valid_in;
   pcsf_pkg::time_type                 s1_time_ff;
   logic [pcsf_pkg::CODE_BITS-1:0]     s1_code_ff;
   logic [pcsf_pkg::SRC_BITS-1:0]      s1_src_ff;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   pcsf_pkg::result_type               rsp_data_ff;

   pcsf_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .write_en   (csr_write_en),
      .index      (csr_index),
      .write_data (csr_write_data),
      .cfg        (cfg)
   );

   pcsf_chan_tab u_chan_tab (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (pcsf_pkg::chan_index(req_bus.source_id, req_bus.data_code)),
      .wr      (tab_wr),
      .look    (look)
   );

   pcsf_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .commit    (s1_commit),
      .time_ms   (s1_time_ff),
      .data_code (s1_code_ff),
      .source_id (s1_src_ff),
      .cfg       (cfg),
      .look      (look),
      .result    (result),
      .tab_wr    (tab_wr)
   );

   assign s1_commit     = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_commit;
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_commit) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_time_ff <= req_bus.time_ms;
         s1_code_ff <= req_bus.data_code;
         s1_src_ff  <= req_bus.source_id;
      end
      if (s1_commit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.keep          = rsp_data_ff.keep;
   assign rsp_bus.drop_reason   = rsp_data_ff.drop_reason;
   assign rsp_bus.segment_start = rsp_data_ff.segment_start;

   // keep and the drop reason agree; only kept samples start segments
   a_rsp_consistent : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (rsp_data_ff.keep == (rsp_data_ff.drop_reason == pcsf_pkg::REASON_KEPT)) &&
         (!rsp_data_ff.segment_start || rsp_data_ff.keep))
      else $error("response keep, reason and segment flag disagree");

   // a request in the decision stage that cannot leave holds its fields
   a_s1_hold : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_commit |=>
         s1_valid_ff && $stable(s1_time_ff) && $stable(s1_code_ff) && $stable(s1_src_ff))
      else $error("stalled request lost or changed in decision stage");

   // every decision reaches the output register on the next edge
   a_commit_to_rsp : assert property (@(posedge clock) disable iff (reset)
      s1_commit |=> rsp_valid_ff)
      else $error("decided request produced no response");

   // the table is written only for kept samples
   a_write_only_kept : assert property (@(posedge clock) disable iff (reset)
      tab_wr.en |-> s1_commit && result.keep)
      else $error("channel table written for a dropped request");

endmodule

[tb/sv/per_channel_sample_filter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_channel_sample_filter_tb
// Self-checking bench for the per-channel sample filter. Opening and closing
// tables of directed samples frame random timed samples under several register
// settings, with random idling on requests and back-pressure on responses.
// Every response is checked in order against a directed row's fixed verdict or
// an in-bench predictor of the ordering, removal, interval and segment rules.
// ----------------------------------------------------------------------------
module per_channel_sample_filter_tb;

   localparam int unsigned CYCLE_LIMIT    = 1_000_000;
   localparam int          RESET_CYCLES   = 11;
   localparam int          SETTLE_CYCLES  = 4;
   localparam int          RANDOM_PHASES  = 6;
   localparam int          PHASE_REQUESTS = 125;
   localparam int          REPORT_LINES   = 40;
   localparam logic [63:0] ROOM_TOP       = 64'h0000_7000_0000_0000;
   localparam logic [63:0] TIME_CEILING   = 64'h0000_7FFF_FFFF_0000;
   localparam pcsf_pkg::time_type TIME_MAX = '1;

   typedef enum {PROBE_SAMPLE, PROBE_SETTINGS, PROBE_BREAK} probe_kind_type;

   typedef struct {
      probe_kind_type                   kind;
      pcsf_pkg::time_type               t;
      logic [pcsf_pkg::CODE_BITS-1:0]   code;
      logic [pcsf_pkg::SRC_BITS-1:0]    src;
      bit                               fixed;
      pcsf_pkg::result_type             want;
   } probe_row_type;

   typedef struct {
      int unsigned          seq;
      pcsf_pkg::result_type want;
   } verdict_entry_type;

   logic                               clock;
   logic                               reset;
   logic                               csr_write_en;
   logic [pcsf_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [pcsf_pkg::CSR_DATA_BITS-1:0] csr_write_data;

   pcsf_req_if req_bus ();
   pcsf_rsp_if rsp_bus ();

   per_channel_sample_filter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // predictor state
   pcsf_pkg::cfg_type  active_cfg = '0;
   pcsf_pkg::time_type order_time;
   bit                 order_seen;
   pcsf_pkg::time_type chan_time [pcsf_pkg::NUM_CHANNELS];
   bit                 chan_seen [pcsf_pkg::NUM_CHANNELS];
   pcsf_pkg::time_type gps_time;
   bit                 gps_seen;

   verdict_entry_type  pending_verdicts [$];
   probe_row_type      probes [$];
   pcsf_pkg::cfg_type  probe_cfgs [$];

   logic [pcsf_pkg::CODE_BITS-1:0] code_pool [3];
   bit                             steady;
   int unsigned                    ready_hold;
   int unsigned                    cycle_count;
   int unsigned                    mismatches;
   int unsigned                    issued;
   int unsigned                    settings_used;
   int unsigned                    reason_tally [4];
   int unsigned                    segment_tally;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic pcsf_pkg::result_type verdict(logic keep, pcsf_pkg::reason_type why,
                                                    logic seg);
      pcsf_pkg::result_type r;
      r.keep          = keep;
      r.drop_reason   = why;
      r.segment_start = seg;
      return r;
   endfunction

   function automatic pcsf_pkg::result_type predict_verdict(
         pcsf_pkg::time_type t, logic [pcsf_pkg::CODE_BITS-1:0] code,
         logic [pcsf_pkg::SRC_BITS-1:0] src);
      pcsf_pkg::chan_addr_type ch;
      logic                    seg;
      if (order_seen && t < order_time) begin
         return verdict(1'b0, pcsf_pkg::REASON_ORDER, 1'b0);
      end
      order_time = t;
      order_seen = 1'b1;
      if (active_cfg.remove_mask[src][code]) begin
         return verdict(1'b0, pcsf_pkg::REASON_REMOVED, 1'b0);
      end
      ch = {src, code};
      if (chan_seen[ch] &&
          (t < chan_time[ch] ||
           t - chan_time[ch] < pcsf_pkg::time_type'(active_cfg.min_period))) begin
         return verdict(1'b0, pcsf_pkg::REASON_DOWNSAMPLED, 1'b0);
      end
      chan_time[ch] = t;
      chan_seen[ch] = 1'b1;
      seg = 1'b0;
      if (code == active_cfg.gps_code) begin
         seg = !gps_seen ||
               (t >= gps_time &&
                t - gps_time > pcsf_pkg::time_type'(active_cfg.gap_thresh));
         gps_time = t;
         gps_seen = 1'b1;
      end
      return verdict(1'b1, pcsf_pkg::REASON_KEPT, seg);
   endfunction

   function automatic int unsigned idle_length();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_sample(pcsf_pkg::time_type t, int code, int src, bit fixed,
                                      pcsf_pkg::result_type want);
      probe_row_type row;
      row.kind  = PROBE_SAMPLE;
      row.t     = t;
      row.code  = pcsf_pkg::CODE_BITS'(code);
      row.src   = pcsf_pkg::SRC_BITS'(src);
      row.fixed = fixed;
      row.want  = want;
      probes    = {probes, row};
   endfunction

   function automatic void add_marker(probe_kind_type kind);
      probe_row_type row;
      row.kind = kind;
      probes   = {probes, row};
   endfunction

   function automatic pcsf_pkg::cfg_type draw_settings(int phase);
      pcsf_pkg::cfg_type c;
      case (phase)
         0: begin
            c.min_period = '0;
            c.gap_thresh = '0;
            c.gps_code   = '0;
         end
         1: begin
            c.min_period = '1;
            c.gap_thresh = '1;
            c.gps_code   = '1;
         end
         default: begin
            c.min_period = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 40);
            c.gap_thresh = $urandom_range(0, 120);
            c.gps_code   = pcsf_pkg::CODE_BITS'($urandom_range(0, pcsf_pkg::NUM_CODES - 1));
         end
      endcase
      for (int s = 0; s < pcsf_pkg::MASK_REGS; s++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: c.remove_mask[s] = '0;
            4, 5, 6, 7: c.remove_mask[s] = {$urandom & $urandom & $urandom,
                                            $urandom & $urandom & $urandom};
            8:          c.remove_mask[s] = '1;
            default:    c.remove_mask[s] = {$urandom, $urandom};
         endcase
      end
      return c;
   endfunction

   function automatic pcsf_pkg::time_type draw_time(bit leap);
      logic [63:0] base;
      logic [63:0] step;
      logic [63:0] room;
      int unsigned r;
      base = 64'(order_time);
      r    = leap ? 99 : $urandom_range(0, 99);
      if (r < 8) begin
         return (base > 5000) ? pcsf_pkg::time_type'(base - $urandom_range(1, 5000))
                              : pcsf_pkg::time_type'(base);
      end
      if (r < 30) begin
         step = $urandom_range(0, 3);
      end else if (r < 60) begin
         step = $urandom_range(0, active_cfg.min_period >> 1);
      end else if (r < 75) begin
         step = 64'(active_cfg.min_period) + $urandom_range(0, 2);
         if (step != 0) step = step - 1;
      end else if (r < 90) begin
         step = 64'(active_cfg.gap_thresh) + $urandom_range(0, 2);
         if (step != 0) step = step - 1;
      end else if (r < 99) begin
         step = $urandom_range(0, 100000);
      end else begin
         room = (base < ROOM_TOP) ? ROOM_TOP - base : 64'd1;
         step = {$urandom, $urandom} % room;
      end
      if (base + step > TIME_CEILING) step = 0;
      return pcsf_pkg::time_type'(base + step);
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LINES) $display("[%0t] MISMATCH %s", $time, what);
   endtask

   task automatic issue_sample(input pcsf_pkg::time_type t,
                               input logic [pcsf_pkg::CODE_BITS-1:0] code,
                               input logic [pcsf_pkg::SRC_BITS-1:0] src, input bit fixed,
                               input pcsf_pkg::result_type want);
      verdict_entry_type    e;
      pcsf_pkg::result_type model;
      int unsigned          pause;
      req_bus.valid     <= 1'b1;
      req_bus.time_ms   <= t;
      req_bus.data_code <= code;
      req_bus.source_id <= src;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      model  = predict_verdict(t, code, src);
      e.seq  = issued;
      e.want = fixed ? want : model;
      pending_verdicts = {pending_verdicts, e};
      issued++;
      reason_tally[e.want.drop_reason]++;
      if (e.want.segment_start) segment_tally++;
      pause = idle_length();
      if (pause != 0) begin
         req_bus.valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input pcsf_pkg::cfg_type c);
      csr_write_en   <= 1'b1;
      csr_index      <= pcsf_pkg::REG_MIN_PERIOD;
      csr_write_data <= pcsf_pkg::CSR_DATA_BITS'(c.min_period);
      @(posedge clock);
      csr_index      <= pcsf_pkg::REG_GAP_THRESH;
      csr_write_data <= pcsf_pkg::CSR_DATA_BITS'(c.gap_thresh);
      @(posedge clock);
      csr_index      <= pcsf_pkg::REG_GPS_CODE;
      csr_write_data <= pcsf_pkg::CSR_DATA_BITS'(c.gps_code);
      @(posedge clock);
      for (int i = 0; i < pcsf_pkg::MASK_REGS; i++) begin
         csr_index      <= pcsf_pkg::REG_MASK_SRC0 + pcsf_pkg::CSR_IDX_BITS'(i);
         csr_write_data <= c.remove_mask[i];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      active_cfg = c;
      settings_used++;
   endtask

   task automatic run_probes();
      probe_row_type row;
      while (probes.size() != 0) begin
         row = probes.pop_front();
         case (row.kind)
            PROBE_SAMPLE: begin
               issue_sample(row.t, row.code, row.src, row.fixed, row.want);
            end
            PROBE_SETTINGS: begin
               drain_responses();
               apply_settings(probe_cfgs.pop_front());
            end
            PROBE_BREAK: begin
               return;
            end
            default: ;
         endcase
      end
   endtask

   always @(posedge clock) begin : ready_pattern
      int unsigned stall;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_hold = 0;
      end else if (steady) begin
         rsp_bus.ready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold--;
      end else if (rsp_bus.ready) begin
         stall = idle_length();
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            ready_hold = stall - 1;
         end else begin
            ready_hold = $urandom_range(0, 15);
         end
      end else begin
         rsp_bus.ready <= 1'b1;
         ready_hold = $urandom_range(0, 15);
      end
   end

   always @(posedge clock) begin : response_check
      verdict_entry_type head;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            head = pending_verdicts.pop_front();
            if (rsp_bus.keep !== head.want.keep)
               report_mismatch($sformatf("request %0d keep %b, expected %b",
                                         head.seq, rsp_bus.keep, head.want.keep));
            if (rsp_bus.drop_reason !== head.want.drop_reason)
               report_mismatch($sformatf("request %0d drop_reason %0d, expected %s",
                                         head.seq, rsp_bus.drop_reason,
                                         head.want.drop_reason.name()));
            if (rsp_bus.segment_start !== head.want.segment_start)
               report_mismatch($sformatf("request %0d segment_start %b, expected %b",
                                         head.seq, rsp_bus.segment_start,
                                         head.want.segment_start));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding",
                  cycle_count, pending_verdicts.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      pcsf_pkg::cfg_type              c;
      int unsigned                    pick;
      logic [pcsf_pkg::CODE_BITS-1:0] code;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.time_ms   <= '0;
      req_bus.data_code <= '0;
      req_bus.source_id <= '0;
      csr_write_en      <= 1'b0;
      csr_index         <= '0;
      csr_write_data    <= '0;
      steady            = 1'b0;

      // opening table, reset settings first
      add_sample(48'd100,  0, 0, 1'b1, verdict(1'b1, pcsf_pkg::REASON_KEPT, 1'b1));
      add_sample(48'd50,   5, 1, 1'b1, verdict(1'b0, pcsf_pkg::REASON_ORDER, 1'b0));
      add_sample(48'd100,  5, 1, 1'b1, verdict(1'b1, pcsf_pkg::REASON_KEPT, 1'b0));
      add_sample(48'd100,  5, 1, 1'b1, verdict(1'b1, pcsf_pkg::REASON_KEPT, 1'b0));
      add_sample(48'd100,  0, 0, 1'b1, verdict(1'b1, pcsf_pkg::REASON_KEPT, 1'b0));
      add_sample(48'd101,  0, 0, 1'b1, verdict(1'b1, pcsf_pkg::REASON_KEPT, 1'b1));
      c.min_period     = 32'd1000;
      c.gap_thresh     = 32'd5000;
      c.gps_code       = 6'd63;
      c.remove_mask[0] = 64'h8000_0000_0000_0080;
      c.remove_mask[1] = '0;
      c.remove_mask[2] = '1;
      c.remove_mask[3] = 64'h1;
      probe_cfgs = {probe_cfgs, c};
      add_marker(PROBE_SETTINGS);
      add_sample(48'd2000,  7, 0, 1'b1, verdict(1'b0, pcsf_pkg::REASON_REMOVED, 1'b0));
      add_sample(48'd2000, 12, 2, 1'b1, verdict(1'b0, pcsf_pkg::REASON_REMOVED, 1'b0));
      add_sample(48'd2000,  0, 3, 1'b1, verdict(1'b0, pcsf_pkg::REASON_REMOVED, 1'b0));
      add_sample(48'd2000, 63, 1, 1'b0, '0);
      add_sample(48'd2999, 63, 1, 1'b1, verdict(1'b0, pcsf_pkg::REASON_DOWNSAMPLED, 1'b0));
      add_sample(48'd3000, 63, 1, 1'b0, '0);
      add_sample(48'd9001, 63, 1, 1'b0, '0);
      add_sample(48'd9001, 63, 0, 1'b1, verdict(1'b0, pcsf_pkg::REASON_REMOVED, 1'b0));
      add_sample(48'd9000,  1, 0, 1'b1, verdict(1'b0, pcsf_pkg::REASON_ORDER, 1'b0));
      add_sample(48'd9500,  5, 1, 1'b0, '0);
      add_sample(48'd9500,  5, 1, 1'b1, verdict(1'b0, pcsf_pkg::REASON_DOWNSAMPLED, 1'b0));
      add_marker(PROBE_BREAK);

      // closing table: the largest time ends the run, since time never goes back
      c.min_period     = '1;
      c.gap_thresh     = '1;
      c.gps_code       = 6'd63;
      c.remove_mask[0] = '0;
      c.remove_mask[1] = '0;
      c.remove_mask[2] = '1;
      c.remove_mask[3] = '0;
      probe_cfgs = {probe_cfgs, c};
      add_marker(PROBE_SETTINGS);
      add_sample(TIME_MAX,     63, 3, 1'b1, verdict(1'b1, pcsf_pkg::REASON_KEPT, 1'b1));
      add_sample(TIME_MAX,     63, 3, 1'b1,
                 verdict(1'b0, pcsf_pkg::REASON_DOWNSAMPLED, 1'b0));
      add_sample(TIME_MAX,     10, 2, 1'b1, verdict(1'b0, pcsf_pkg::REASON_REMOVED, 1'b0));
      add_sample(TIME_MAX - 1,  0, 0, 1'b1, verdict(1'b0, pcsf_pkg::REASON_ORDER, 1'b0));
      add_sample('0,            0, 0, 1'b1, verdict(1'b0, pcsf_pkg::REASON_ORDER, 1'b0));
      add_sample(TIME_MAX,     62, 1, 1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      run_probes();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_responses();
         apply_settings(draw_settings(phase));
         steady = (phase == 2) || ($urandom_range(0, 3) == 0);
         foreach (code_pool[k])
            code_pool[k] = pcsf_pkg::CODE_BITS'($urandom_range(0, pcsf_pkg::NUM_CODES - 1));
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               code = active_cfg.gps_code;
            end else if (pick < 80) begin
               code = code_pool[$urandom_range(0, 2)];
            end else begin
               code = pcsf_pkg::CODE_BITS'($urandom_range(0, pcsf_pkg::NUM_CODES - 1));
            end
            issue_sample(draw_time(phase == RANDOM_PHASES - 1 && n == 0), code,
                         pcsf_pkg::SRC_BITS'($urandom_range(0, pcsf_pkg::NUM_SOURCES - 1)),
                         1'b0, '0);
            // now and then, hold off until every response is back
            if ($urandom_range(0, 99) == 0) drain_responses();
         end
      end

      steady = 1'b0;
      run_probes();
      drain_responses();

      if (pending_verdicts.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_verdicts.size()));

      $display("Sent %0d samples under %0d register settings with random idling and stalls.",
               issued, settings_used);
      $display("Verdicts: %0d kept, %0d segment starts, %0d order, %0d removed, %0d downsampled.",
               reason_tally[pcsf_pkg::REASON_KEPT], segment_tally,
               reason_tally[pcsf_pkg::REASON_ORDER],
               reason_tally[pcsf_pkg::REASON_REMOVED],
               reason_tally[pcsf_pkg::REASON_DOWNSAMPLED]);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
